@@ sv/brb_pkg.sv @@
// ----------------------------------------------------------------------------
// brb_pkg
// shared sizes, types and helpers for the byte ring buffer
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DEPTH   = 256;
  localparam int PTR_W   = 8;
  localparam int FILL_W  = 9;
  localparam int MAX_GET = 64;
  localparam int CNT_W   = 7;
  localparam int CAP_W   = 9;

  localparam logic [CNT_W-1:0]  MAX_GET_C = CNT_W'(MAX_GET);

  // register index on the configuration port
  localparam logic REG_CAPACITY = 1'b0;

  // request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_GET  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_GET
  } state_t;

  // step a slot pointer, wrapping at the usable capacity
  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] s;
    s = CAP_W'(p) + CAP_W'(1);
    return (s >= cap) ? '0 : s[PTR_W-1:0];
  endfunction

endpackage

@@ sv/brb_ram.sv @@
// ----------------------------------------------------------------------------
// brb_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int DW = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/byte_ring_buffer_core.sv @@
// ----------------------------------------------------------------------------
// byte_ring_buffer_core
// circular byte fifo with configurable capacity, burst push and counted get
// ----------------------------------------------------------------------------
//  channel   dir  handshake            contents
//  s_*       in   s_tvalid/s_tready    push byte or get request
//  m_*       out  m_tvalid/m_tready    status, read byte, fill and pointers
//  apb       in   psel/penable/pready  capacity register at byte address 0
//
//  a push does the ram write and the result load in the accepting cycle
//  a get of n bytes holds the input through the accept, n ram reads and
//  the move of the last byte into the output register
//  an empty get gives its single result in the accepting cycle
//  rst is synchronous and empties the buffer, capacity returns to 256
//  a stalled output halts the read stream once the read stage holds a byte; no input is taken mid get
// ----------------------------------------------------------------------------
module byte_ring_buffer_core (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // burst_len[8:0], push_byte[16:9], get_max[23:17]
  input  logic [1:0]  s_tuser,   // req_type[0], burst_first[1]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte[7:0], fill_level[16:8], write_pos[24:17],
                                 // read_pos[32:25], zero[39:33]
  output logic [1:0]  m_tuser,   // status[0], out_valid[1]
  output logic        m_tlast
);

  localparam int PW = brb_pkg::PTR_W;
  localparam int FW = brb_pkg::FILL_W;
  localparam int CW = brb_pkg::CNT_W;
  localparam int AW = brb_pkg::CAP_W;

  // ---- request fields
  logic          req_type;
  logic          burst_first;
  logic [FW-1:0] burst_len;
  logic [7:0]    push_byte;
  logic [CW-1:0] get_max;

  assign req_type    = s_tuser[0];
  assign burst_first = s_tuser[1];
  assign burst_len   = s_tdata[8:0];
  assign push_byte   = s_tdata[16:9];
  assign get_max     = s_tdata[23:17];

  // ---- architectural state
  brb_pkg::state_t state, state_next;
  logic [AW-1:0] capacity;
  logic [PW-1:0] write_index;
  logic [PW-1:0] read_index;
  logic [FW-1:0] fill_count;
  logic          burst_rejected;
  logic [CW-1:0] get_left;

  // read stage between ram and output register
  logic          rd_busy;
  logic [FW-1:0] pend_fill;
  logic [PW-1:0] pend_rpos;
  logic          pend_last;

  // output register
  logic          o_status;
  logic          o_valid;
  logic [7:0]    o_byte;
  logic          o_last;
  logic [FW-1:0] o_fill;
  logic [PW-1:0] o_wpos;
  logic [PW-1:0] o_rpos;

  // ---- configuration port
  logic          cfg_wr;
  logic [AW-1:0] cfg_val;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == brb_pkg::REG_CAPACITY);

  always_comb begin
    cfg_val = pwdata[AW-1:0];
    if (cfg_val == '0) begin
      cfg_val = AW'(1);
    end else if (cfg_val > AW'(brb_pkg::DEPTH)) begin
      cfg_val = AW'(brb_pkg::DEPTH);
    end
  end

  assign prdata = (paddr[2] == brb_pkg::REG_CAPACITY) ? {{(32-AW){1'b0}}, capacity} : '0;

  // ---- common handshake terms
  logic out_free;
  logic in_acc;
  logic is_push;
  logic is_get;

  assign out_free = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;
  assign is_push  = in_acc && (req_type == brb_pkg::REQ_PUSH);
  assign is_get   = in_acc && (req_type == brb_pkg::REQ_GET);

  // ---- push decision
  logic          rej_new;
  logic          drop;
  logic [FW:0]   need;

  assign need    = (FW+1)'(burst_len) + (FW+1)'(fill_count);
  assign rej_new = burst_first ? (need > (FW+1)'(capacity)) : burst_rejected;
  assign drop    = rej_new || (fill_count >= capacity);

  // ---- get length: min(fill, saturated get_max)
  logic [CW-1:0] gm_sat;
  logic [CW-1:0] get_n;

  assign gm_sat = (get_max > brb_pkg::MAX_GET_C) ? brb_pkg::MAX_GET_C : get_max;
  assign get_n  = (fill_count < FW'(gm_sat)) ? fill_count[CW-1:0] : gm_sat;

  // ---- read issue and transfer of the read stage
  logic          rd_issue;
  logic          rd_move;
  logic [PW-1:0] rd_next_idx;
  logic [7:0]    rd_data;

  assign rd_next_idx = brb_pkg::ptr_adv(read_index, capacity);
  assign rd_move     = rd_busy && out_free;

  // ---- state machine: next state
  always_comb begin
    state_next = state;
    case (state)
      brb_pkg::ST_IDLE: begin
        if (is_get && (get_n != '0)) begin
          state_next = brb_pkg::ST_GET;
        end
      end
      brb_pkg::ST_GET: begin
        if (rd_issue && (get_left == CW'(1))) begin
          state_next = brb_pkg::ST_IDLE;
        end
      end
      default: state_next = brb_pkg::ST_IDLE;
    endcase
  end

  // ---- state machine: outputs
  // no input while a read is in flight, so a ram write never meets a read
  always_comb begin
    s_tready = 1'b0;
    rd_issue = 1'b0;
    case (state)
      brb_pkg::ST_IDLE: begin
        s_tready = out_free && !rd_busy;
      end
      brb_pkg::ST_GET: begin
        rd_issue = (get_left != '0) && (!rd_busy || out_free);
      end
      default: begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
      end
    endcase
  end

  // ---- byte store
  brb_ram #(
    .DW (8),
    .AW (PW)
  ) u_ram (
    .clk   (clk),
    .we    (is_push && !drop),
    .waddr (write_index),
    .wdata (push_byte),
    .re    (rd_issue),
    .raddr (read_index),
    .rdata (rd_data)
  );

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= brb_pkg::ST_IDLE;
      capacity       <= AW'(brb_pkg::DEPTH);
      write_index    <= '0;
      read_index     <= '0;
      fill_count     <= '0;
      burst_rejected <= 1'b0;
      get_left       <= '0;
      rd_busy        <= 1'b0;
    end else if (cfg_wr) begin
      // a capacity write empties the buffer
      capacity       <= cfg_val;
      write_index    <= '0;
      read_index     <= '0;
      fill_count     <= '0;
      burst_rejected <= 1'b0;
    end else begin
      state <= state_next;
      if (is_push) begin
        burst_rejected <= rej_new;
        if (!drop) begin
          fill_count  <= fill_count + FW'(1);
          write_index <= brb_pkg::ptr_adv(write_index, capacity);
        end
      end
      if (is_get) begin
        get_left <= get_n;
      end
      if (rd_issue) begin
        get_left   <= get_left - CW'(1);
        fill_count <= fill_count - FW'(1);
        read_index <= rd_next_idx;
        rd_busy    <= 1'b1;
      end else if (rd_move) begin
        rd_busy <= 1'b0;
      end
    end
  end

  // state after a read, carried alongside the ram access
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_fill <= fill_count - FW'(1);
      pend_rpos <= rd_next_idx;
      pend_last <= (get_left == CW'(1));
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_acc && (is_push || get_n == '0)) begin
      m_tvalid <= 1'b1;
    end else if (rd_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_push) begin
      o_status <= drop;
      o_valid  <= 1'b0;
      o_byte   <= '0;
      o_last   <= 1'b1;
      o_fill   <= drop ? fill_count : fill_count + FW'(1);
      o_wpos   <= drop ? write_index : brb_pkg::ptr_adv(write_index, capacity);
      o_rpos   <= read_index;
    end else if (is_get && (get_n == '0)) begin
      // empty get: one result without data
      o_status <= 1'b0;
      o_valid  <= 1'b0;
      o_byte   <= '0;
      o_last   <= 1'b1;
      o_fill   <= fill_count;
      o_wpos   <= write_index;
      o_rpos   <= read_index;
    end else if (rd_move) begin
      o_status <= 1'b0;
      o_valid  <= 1'b1;
      o_byte   <= rd_data;
      o_last   <= pend_last;
      o_fill   <= pend_fill;
      o_wpos   <= write_index;
      o_rpos   <= pend_rpos;
    end
  end

  assign m_tdata = {7'b0, o_rpos, o_wpos, o_fill, o_byte};
  assign m_tuser = {o_valid, o_status};
  assign m_tlast = o_last;

endmodule

@@ sv/brb_checker.sv @@
// ----------------------------------------------------------------------------
// brb_port_checks
// port level checks on the result stream of the byte ring buffer
// ----------------------------------------------------------------------------
module brb_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a rejected push never carries a byte
  a_rej_nodata: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && m_tlast)
    else $error("overflow result with data");

  // results without data always end their transaction
  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tlast && (m_tdata[7:0] == 8'd0))
    else $error("dataless result not last");

  // after a byte is read out the fill level is below DEPTH
  a_read_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[16:8] < 9'(brb_pkg::DEPTH))
    else $error("fill level too high after read");

endmodule

bind byte_ring_buffer_core brb_port_checks u_brb_port_checks (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
